[hw/rtl/ccfd_pkg.sv]
`timescale 1ns / 1ps

package ccfd_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0] DelimReset    = 8'd0;
  localparam logic [7:0] MaxLenReset   = 8'd255;
  localparam logic [7:0] MaxCountReset = 8'd16;

  typedef enum logic [1:0] {
    CFG_DELIMITER = 2'd0,
    CFG_MAX_LEN   = 2'd1,
    CFG_MAX_COUNT = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_LONG  = 3'd1,
    ST_DELIM = 3'd2,
    ST_RUN   = 3'd3,
    ST_LEN   = 3'd4,
    ST_CRC   = 3'd5,
    ST_COUNT = 3'd6,
    ST_RSVD  = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_delim;
    logic [7:0] run;
  } item_t;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [7:0] max_len;
    logic [7:0] max_count;
  } cfg_t;

  function automatic logic [15:0] crc_push(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/ccfd_intf.sv]
`timescale 1ns / 1ps

interface ccfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface ccfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       data_valid;
  logic       frame_end;
  logic [2:0] frame_status;
  modport source (output valid, out_byte, data_valid, frame_end, frame_status, input ready);
  modport sink (input valid, out_byte, data_valid, frame_end, frame_status, output ready);
endinterface

interface ccfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/cobs_crc_frame_decoder.sv]
`timescale 1ns / 1ps

// Stuffed frame decoder with CRC-16/CCITT check.
// in_i carries one stuffed byte per transaction with in_last marking the final
// byte of a frame; frames carry no delimiter. out_o returns at most one
// transaction per input byte: a decoded byte (data_valid), and on the last
// byte also frame_end with frame_status. A code byte at frame start and bytes
// after the first error produce no transaction unless they are the last byte.
// cfg_i writes delimiter_value (0), max_frame_length (1) and
// max_message_count (2); other indexes are ignored. Write only while idle.
// Throughput is one byte per cycle while the receiver takes results. An
// accepted byte enters a four-entry queue and is decoded from the queue head
// into the output register. The decode step (run counter, byte-wide CRC
// update, error checks) is combinational between the two.
// When the receiver stalls, the output register holds its result, the queue
// fills, and in_i.ready drops once four bytes wait.
// Reset clears the queue, the frame state and the output valid flag, and
// restores the register defaults 0, 255 and 16.
module cobs_crc_frame_decoder import ccfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ccfd_in_if.sink    in_i,
  ccfd_out_if.source out_o,
  ccfd_cfg_if.sink   cfg_i
);

  cfg_t  cfg_q;
  logic  full;
  logic  push;
  item_t push_item;
  logic  head_valid;
  item_t head_item;
  logic  pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter <= DelimReset;
      cfg_q.max_len   <= MaxLenReset;
      cfg_q.max_count <= MaxCountReset;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_DELIMITER: cfg_q.delimiter <= cfg_i.data;
        CFG_MAX_LEN:   cfg_q.max_len   <= cfg_i.data;
        CFG_MAX_COUNT: cfg_q.max_count <= cfg_i.data;
        default: ;
      endcase
    end
  end

  ccfd_front u_front (
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .queue_full_i (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  ccfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  ccfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (head_valid),
    .item_i       (head_item),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

[hw/rtl/ccfd_front.sv]
`timescale 1ns / 1ps

module ccfd_front import ccfd_pkg::*; (
  ccfd_in_if.sink  in_i,
  input  cfg_t     cfg_i,
  input  logic     queue_full_i,
  output logic     push_o,
  output item_t    item_o
);

  logic [7:0] code_len;

  assign in_i.ready = ~queue_full_i;
  assign push_o     = in_i.valid & ~queue_full_i;

  // A code byte of zero announces a run as long as the delimiter value.
  assign code_len = (in_i.in_byte == 8'd0) ? cfg_i.delimiter : in_i.in_byte;

  assign item_o.data     = in_i.in_byte;
  assign item_o.last     = in_i.in_last;
  assign item_o.is_delim = (in_i.in_byte == cfg_i.delimiter);
  assign item_o.run      = code_len - 8'd1;

endmodule

[hw/rtl/ccfd_queue.sv]
`timescale 1ns / 1ps

module ccfd_queue import ccfd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue occupancy exceeds its depth");

endmodule

[hw/rtl/ccfd_back.sv]
`timescale 1ns / 1ps

module ccfd_back import ccfd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  pop_o,
  ccfd_out_if.source out_o
);

  logic        at_start_q, at_start_d;
  logic [7:0]  run_q, run_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  msg_q, msg_d;
  status_e     err_q, err_d;

  logic        ovalid_q, ovalid_d;
  logic [7:0]  obyte_q;
  logic        odv_q;
  logic        oend_q;
  status_e     ostat_q;

  logic        emit;
  logic [7:0]  ob;
  logic [8:0]  cnt_inc;
  status_e     status;
  logic        load;

  assign pop_o = item_valid_i & (~ovalid_q | out_o.ready);

  always_comb begin
    at_start_d = at_start_q;
    run_d      = run_q;
    crc_d      = crc_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    msg_d      = msg_q;
    err_d      = err_q;
    emit       = 1'b0;
    ob         = 8'd0;
    status     = ST_OK;
    cnt_inc    = {1'b0, cnt_q} + 9'd1;

    if (at_start_q) begin
      at_start_d = 1'b0;
      if (item_i.is_delim && err_q == ST_OK) begin
        err_d = ST_DELIM;
      end
      run_d = item_i.run;
    end else begin
      if (cnt_inc > {1'b0, cfg_i.max_len}) begin
        err_d = ST_LONG;
      end
      cnt_d = cnt_inc[8] ? 8'hFF : cnt_inc[7:0];
      if (err_d == ST_OK && item_i.is_delim) begin
        err_d = ST_DELIM;
      end
      if (err_d == ST_OK) begin
        if (run_q != 8'd0) begin
          ob    = item_i.data;
          run_d = run_q - 8'd1;
        end else begin
          ob    = cfg_i.delimiter;
          run_d = item_i.run;
        end
        emit  = 1'b1;
        crc_d = crc_push(crc_q, ob);
        if (cnt_d == 8'd1) begin
          len_d = ob;
        end else if (cnt_d == 8'd2) begin
          msg_d = ob;
        end
      end
    end

    if (item_i.last) begin
      if (err_d != ST_OK) begin
        status = err_d;
      end else if (run_d != 8'd0) begin
        status = ST_RUN;
      end else if (cnt_d < 8'd2 || (cnt_d - 8'd2) != len_d) begin
        status = ST_LEN;
      end else if (crc_d != 16'd0) begin
        status = ST_CRC;
      end else if (msg_d < 8'd1 || msg_d > cfg_i.max_count) begin
        status = ST_COUNT;
      end
      at_start_d = 1'b1;
      run_d      = 8'd0;
      crc_d      = CrcInit;
      cnt_d      = 8'd0;
      len_d      = 8'd0;
      msg_d      = 8'd0;
      err_d      = ST_OK;
    end
  end

  assign load = pop_o & (emit | item_i.last);

  always_comb begin
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      run_q      <= 8'd0;
      crc_q      <= CrcInit;
      cnt_q      <= 8'd0;
      len_q      <= 8'd0;
      msg_q      <= 8'd0;
      err_q      <= ST_OK;
      ovalid_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        at_start_q <= at_start_d;
        run_q      <= run_d;
        crc_q      <= crc_d;
        cnt_q      <= cnt_d;
        len_q      <= len_d;
        msg_q      <= msg_d;
        err_q      <= err_d;
      end
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= ob;
      odv_q   <= emit;
      oend_q  <= item_i.last;
      ostat_q <= status;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.out_byte     = obyte_q;
  assign out_o.data_valid   = odv_q;
  assign out_o.frame_end    = oend_q;
  assign out_o.frame_status = ostat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    at_start_q |-> (err_q == ST_OK && cnt_q == 8'd0 && crc_q == CrcInit))
    else $error("frame state not clear at frame start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.last) |=> at_start_q)
    else $error("last byte did not close the frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && odv_q && oend_q) |-> (ostat_q != ST_LONG && ostat_q != ST_DELIM))
    else $error("decoded byte emitted together with a framing error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_o.ready && !pop_o) |=> ovalid_q)
    else $error("pending result dropped");

endmodule
